@@ hdl/binary_heap_priority_queue_macros.svh @@
// assertion helpers for the checker file
`ifndef BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, gated by reset
`define BHPQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bhpq assertion failed");

// next-cycle implication, gated by reset
`define BHPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bhpq assertion failed");

`endif

@@ hdl/bhpq_pkg.sv @@
package bhpq_pkg;

    localparam int CAPACITY     = 255;
    localparam int KEY_BITS     = 16;
    localparam int PAYLOAD_BITS = 16;
    localparam int COUNT_BITS   = 8;
    localparam int ADDR_BITS    = $clog2(CAPACITY + 1);
    localparam int DEPTH        = 1 << ADDR_BITS;

    typedef logic [KEY_BITS-1:0]     key_t;
    typedef logic [PAYLOAD_BITS-1:0] payload_t;
    typedef logic [COUNT_BITS-1:0]   count_t;
    typedef logic [ADDR_BITS-1:0]    addr_t;
    typedef logic [ADDR_BITS:0]      child_t;

    typedef struct packed {
        key_t     key;
        payload_t payload;
    } entry_t;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam logic ORDER_MAX_FIRST = 1'b0;
    localparam logic ORDER_MIN_FIRST = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

endpackage

@@ hdl/bhpq_channels.sv @@
interface bhpq_cmd_if;
    logic              valid;
    logic              ready;
    logic              opcode;
    bhpq_pkg::key_t     key;
    bhpq_pkg::payload_t payload;

    modport source (output valid, output opcode, output key, output payload, input ready);
    modport sink   (input valid, input opcode, input key, input payload, output ready);
endinterface

interface bhpq_rsp_if;
    logic              valid;
    logic              ready;
    bhpq_pkg::key_t     out_key;
    bhpq_pkg::payload_t out_payload;
    logic [1:0]        status;
    bhpq_pkg::count_t   entry_count;

    modport source (output valid, output out_key, output out_payload, output status,
                    output entry_count, input ready);
    modport sink   (input valid, input out_key, input out_payload, input status,
                    input entry_count, output ready);
endinterface

interface bhpq_cfg_if;
    logic valid;
    logic ready;
    logic order_mode;

    modport source (output valid, output order_mode, input ready);
    modport sink   (input valid, input order_mode, output ready);
endinterface

@@ hdl/bhpq_rank.sv @@
module bhpq_rank (
    input  logic           order_mode,
    input  bhpq_pkg::key_t key_a,
    input  bhpq_pkg::key_t key_b,
    output logic           b_higher
);
    import bhpq_pkg::*;

    // strict: equal keys never rank higher
    always_comb
    begin
        if (order_mode == ORDER_MAX_FIRST)
        begin
            b_higher = key_b > key_a;
        end
        else
        begin
            b_higher = key_b < key_a;
        end
    end

endmodule

@@ hdl/binary_heap_priority_queue.sv @@
// one item at a time; cmd.ready is high only while the sequencer is idle
// insert: the item climbs level by level through S_INS_CHK and S_INS_CMP until rsp.valid
// remove: the last entry sinks through S_DEL_CHK, S_DEL_LEFT, S_DEL_RIGHT, S_DEL_CMP; full or empty goes to S_DONE
// the next item can be taken in the same cycle rsp.valid rises; a held result stalls only S_DONE
// the heap memory gives one registered read and one write per cycle
// rst_n clears count, order_mode and the output register; heap memory is not cleared
module binary_heap_priority_queue (
    input  logic        clk,
    input  logic        rst_n,
    bhpq_cmd_if.sink    cmd,
    bhpq_rsp_if.source  rsp,
    bhpq_cfg_if.sink    cfg
);
    import bhpq_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_CHK,
        S_INS_CMP,
        S_DEL_ROOT,
        S_DEL_LAST,
        S_DEL_CHK,
        S_DEL_LEFT,
        S_DEL_RIGHT,
        S_DEL_CMP,
        S_DONE
    } state_t;

    state_t   state_reg;
    count_t   count_reg;
    logic     order_reg;
    addr_t    pos_reg;
    entry_t   item_reg;
    entry_t   child_reg;
    addr_t    cidx_reg;
    entry_t   top_reg;
    status_t  stat_reg;
    logic     rsp_valid_reg;
    entry_t   rsp_entry_reg;
    status_t  rsp_status_reg;
    count_t   rsp_count_reg;

    entry_t   mem [DEPTH];
    entry_t   rd_data_reg;
    addr_t    rd_addr;
    logic     wr_en;
    addr_t    wr_addr;
    entry_t   wr_data;

    child_t   left_idx;
    child_t   right_idx;
    logic     left_ok;
    logic     right_ok;
    key_t     cmp_a;
    key_t     cmp_b;
    logic     b_higher;

    assign left_idx  = {pos_reg, 1'b0};
    assign right_idx = {pos_reg, 1'b1};
    assign left_ok   = left_idx <= {1'b0, count_reg};
    assign right_ok  = right_idx <= {1'b0, count_reg};

    assign cmd.ready       = (state_reg == S_IDLE);
    assign cfg.ready       = 1'b1;
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.out_key     = rsp_entry_reg.key;
    assign rsp.out_payload = rsp_entry_reg.payload;
    assign rsp.status      = rsp_status_reg;
    assign rsp.entry_count = rsp_count_reg;

    // shared compare: does b rank strictly above a
    always_comb
    begin
        case (state_reg)
            S_INS_CMP:
            begin
                cmp_a = rd_data_reg.key;
                cmp_b = item_reg.key;
            end
            S_DEL_RIGHT:
            begin
                cmp_a = child_reg.key;
                cmp_b = rd_data_reg.key;
            end
            default:
            begin
                cmp_a = item_reg.key;
                cmp_b = child_reg.key;
            end
        endcase
    end

    bhpq_rank u_rank (
        .order_mode (order_reg),
        .key_a      (cmp_a),
        .key_b      (cmp_b),
        .b_higher   (b_higher)
    );

    // idle reads the root so it is in the read register when a remove enters S_DEL_ROOT
    always_comb
    begin
        case (state_reg)
            S_IDLE:      rd_addr = addr_t'(1);
            S_DEL_ROOT:  rd_addr = count_reg[ADDR_BITS-1:0];
            S_INS_CHK:   rd_addr = pos_reg >> 1;
            S_DEL_CHK:   rd_addr = left_idx[ADDR_BITS-1:0];
            S_DEL_LEFT:  rd_addr = right_idx[ADDR_BITS-1:0];
            default:     rd_addr = '0;
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pos_reg;
        wr_data = item_reg;
        case (state_reg)
            S_INS_CHK:
            begin
                wr_en = (pos_reg == addr_t'(1));
            end
            S_INS_CMP:
            begin
                wr_en = 1'b1;
                if (b_higher)
                begin
                    wr_data = rd_data_reg;
                end
            end
            S_DEL_CHK:
            begin
                wr_en = !left_ok;
            end
            S_DEL_CMP:
            begin
                wr_en = 1'b1;
                if (b_higher)
                begin
                    wr_data = child_reg;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            order_reg      <= ORDER_MAX_FIRST;
            pos_reg        <= '0;
            item_reg       <= '0;
            child_reg      <= '0;
            cidx_reg       <= '0;
            top_reg        <= '0;
            stat_reg       <= ST_OK;
            rsp_valid_reg  <= 1'b0;
            rsp_entry_reg  <= '0;
            rsp_status_reg <= ST_OK;
            rsp_count_reg  <= '0;
        end
        else
        begin
            if (cfg.valid)
            begin
                order_reg <= cfg.order_mode;
            end
            // the done state reloads the output register on its own
            if (rsp_valid_reg && rsp.ready && (state_reg != S_DONE))
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (cmd.valid)
                    begin
                        top_reg <= '0;
                        if (cmd.opcode == OP_INSERT)
                        begin
                            if (count_reg == count_t'(CAPACITY))
                            begin
                                stat_reg  <= ST_FULL;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                stat_reg  <= ST_OK;
                                item_reg  <= '{key: cmd.key, payload: cmd.payload};
                                pos_reg   <= addr_t'(count_reg + 1'b1);
                                state_reg <= S_INS_CHK;
                            end
                        end
                        else
                        begin
                            if (count_reg == '0)
                            begin
                                stat_reg  <= ST_EMPTY;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                stat_reg  <= ST_OK;
                                state_reg <= S_DEL_ROOT;
                            end
                        end
                    end
                end
                S_INS_CHK:
                begin
                    if (pos_reg == addr_t'(1))
                    begin
                        count_reg <= count_reg + 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_INS_CMP;
                    end
                end
                S_INS_CMP:
                begin
                    if (b_higher)
                    begin
                        pos_reg   <= pos_reg >> 1;
                        state_reg <= S_INS_CHK;
                    end
                    else
                    begin
                        count_reg <= count_reg + 1'b1;
                        state_reg <= S_DONE;
                    end
                end
                S_DEL_ROOT:
                begin
                    top_reg   <= rd_data_reg;
                    state_reg <= S_DEL_LAST;
                end
                S_DEL_LAST:
                begin
                    item_reg  <= rd_data_reg;
                    pos_reg   <= addr_t'(1);
                    state_reg <= S_DEL_CHK;
                end
                S_DEL_CHK:
                begin
                    if (!left_ok)
                    begin
                        count_reg <= count_reg - 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_DEL_LEFT;
                    end
                end
                S_DEL_LEFT:
                begin
                    child_reg <= rd_data_reg;
                    cidx_reg  <= left_idx[ADDR_BITS-1:0];
                    state_reg <= right_ok ? S_DEL_RIGHT : S_DEL_CMP;
                end
                S_DEL_RIGHT:
                begin
                    // right child wins only when it ranks strictly above the left
                    if (b_higher)
                    begin
                        child_reg <= rd_data_reg;
                        cidx_reg  <= right_idx[ADDR_BITS-1:0];
                    end
                    state_reg <= S_DEL_CMP;
                end
                S_DEL_CMP:
                begin
                    if (b_higher)
                    begin
                        pos_reg   <= cidx_reg;
                        state_reg <= S_DEL_CHK;
                    end
                    else
                    begin
                        count_reg <= count_reg - 1'b1;
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (!rsp_valid_reg || rsp.ready)
                    begin
                        rsp_valid_reg  <= 1'b1;
                        rsp_entry_reg  <= top_reg;
                        rsp_status_reg <= stat_reg;
                        rsp_count_reg  <= count_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hdl/bhpq_checker.sv @@
`include "binary_heap_priority_queue_macros.svh"

module bhpq_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              cmd_valid,
    input logic              cmd_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input bhpq_pkg::key_t     rsp_key,
    input bhpq_pkg::payload_t rsp_payload,
    input logic [1:0]        rsp_status,
    input bhpq_pkg::count_t   rsp_count
);
    import bhpq_pkg::*;

    // an empty remove reports nothing taken and an empty heap
    `BHPQ_ASSERT_IMP(a_empty_result, clk, rst_n, rsp_valid && (rsp_status == ST_EMPTY), (rsp_count == '0) && (rsp_key == '0) && (rsp_payload == '0))

    // a rejected insert leaves the heap at capacity
    `BHPQ_ASSERT_IMP(a_full_result, clk, rst_n, rsp_valid && (rsp_status == ST_FULL), (rsp_count == count_t'(CAPACITY)) && (rsp_key == '0))

    // the sequencer is busy the cycle after an item is taken
    `BHPQ_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, cmd_valid && cmd_ready, !cmd_ready)

    `BHPQ_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_key) && $stable(rsp_count) && $stable(rsp_status))

endmodule

bind binary_heap_priority_queue bhpq_checker u_bhpq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd.valid),
    .cmd_ready   (cmd.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_key     (rsp.out_key),
    .rsp_payload (rsp.out_payload),
    .rsp_status  (rsp.status),
    .rsp_count   (rsp.entry_count)
);

@@ sim/tb_binary_heap_priority_queue.sv @@
module tb_binary_heap_priority_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import bhpq_pkg::*;

    localparam int CYCLE_LIMIT = 400_000;
    localparam int TAIL_CYCLES = 60;

    typedef struct packed {
        key_t     key;
        payload_t payload;
        status_t  status;
        count_t   count;
    } heap_result_t;

    typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t    kind;
        logic         mode;
        logic         op;
        key_t         key;
        payload_t     payload;
        bit           typed;
        heap_result_t res;
    } stim_row_t;

    localparam heap_result_t NO_RES = '0;

    // typed rows carry their result, the rest come from the heap predictor
    stim_row_t dir_rows [24] = '{
        '{ROW_ITEM, 1'b0, OP_REMOVE, 16'hffff, 16'hffff, 1'b1, '{16'h0, 16'h0, ST_EMPTY, 8'd0}},
        '{ROW_ITEM, 1'b0, OP_INSERT, 16'h0000, 16'h0000, 1'b1, '{16'h0, 16'h0, ST_OK, 8'd1}},
        '{ROW_ITEM, 1'b0, OP_INSERT, 16'hffff, 16'hffff, 1'b1, '{16'h0, 16'h0, ST_OK, 8'd2}},
        '{ROW_ITEM, 1'b0, OP_INSERT, 16'h8000, 16'h1234, 1'b1, '{16'h0, 16'h0, ST_OK, 8'd3}},
        '{ROW_ITEM, 1'b0, OP_INSERT, 16'h8000, 16'h5678, 1'b1, '{16'h0, 16'h0, ST_OK, 8'd4}},
        '{ROW_ITEM, 1'b0, OP_INSERT, 16'h0001, 16'haaaa, 1'b1, '{16'h0, 16'h0, ST_OK, 8'd5}},
        '{ROW_ITEM, 1'b0, OP_INSERT, 16'h8000, 16'h5555, 1'b1, '{16'h0, 16'h0, ST_OK, 8'd6}},
        '{ROW_ITEM, 1'b0, OP_REMOVE, 16'h1357, 16'h2468, 1'b1,
          '{16'hffff, 16'hffff, ST_OK, 8'd5}},
        '{ROW_ITEM, 1'b0, OP_REMOVE, 16'h0000, 16'h0000, 1'b0, NO_RES},
        '{ROW_ITEM, 1'b0, OP_REMOVE, 16'h0000, 16'h0000, 1'b0, NO_RES},
        '{ROW_ITEM, 1'b0, OP_REMOVE, 16'h0000, 16'h0000, 1'b0, NO_RES},
        '{ROW_ITEM, 1'b0, OP_REMOVE, 16'h0000, 16'h0000, 1'b0, NO_RES},
        '{ROW_ITEM, 1'b0, OP_REMOVE, 16'h0000, 16'h0000, 1'b1, '{16'h0, 16'h0, ST_OK, 8'd0}},
        '{ROW_ITEM, 1'b0, OP_REMOVE, 16'hffff, 16'h0000, 1'b1,
          '{16'h0, 16'h0, ST_EMPTY, 8'd0}},
        '{ROW_CFG, ORDER_MIN_FIRST, OP_INSERT, 16'h0, 16'h0, 1'b0, NO_RES},
        '{ROW_ITEM, 1'b0, OP_INSERT, 16'h5555, 16'h0001, 1'b1, '{16'h0, 16'h0, ST_OK, 8'd1}},
        '{ROW_ITEM, 1'b0, OP_INSERT, 16'h0000, 16'hffff, 1'b1, '{16'h0, 16'h0, ST_OK, 8'd2}},
        '{ROW_ITEM, 1'b0, OP_INSERT, 16'hffff, 16'h0000, 1'b1, '{16'h0, 16'h0, ST_OK, 8'd3}},
        '{ROW_ITEM, 1'b0, OP_INSERT, 16'h0000, 16'h1111, 1'b1, '{16'h0, 16'h0, ST_OK, 8'd4}},
        '{ROW_ITEM, 1'b0, OP_REMOVE, 16'h0000, 16'h0000, 1'b1,
          '{16'h0000, 16'hffff, ST_OK, 8'd3}},
        '{ROW_ITEM, 1'b0, OP_REMOVE, 16'h0000, 16'h0000, 1'b0, NO_RES},
        '{ROW_ITEM, 1'b0, OP_REMOVE, 16'h0000, 16'h0000, 1'b0, NO_RES},
        '{ROW_ITEM, 1'b0, OP_REMOVE, 16'h0000, 16'h0000, 1'b0, NO_RES},
        '{ROW_CFG, ORDER_MAX_FIRST, OP_INSERT, 16'h0, 16'h0, 1'b0, NO_RES}
    };

    logic clk;
    logic rst_n;

    bhpq_cmd_if cmd_ch ();
    bhpq_rsp_if rsp_ch ();
    bhpq_cfg_if cfg_ch ();

    binary_heap_priority_queue uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // predictor state
    key_t         heap_key [1:CAPACITY];
    payload_t     heap_pay [1:CAPACITY];
    int unsigned  heap_size = 0;
    logic         order_q = ORDER_MAX_FIRST;

    heap_result_t pending_results [$];
    int           errors = 0;
    int           cycles = 0;
    int           send_idle_pct = 7;
    int           recv_idle_pct = 52;
    int           hold_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        while (cycles <= CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_binary_heap_priority_queue: errors");
        $finish;
    end

    function automatic int key_rank(key_t a, key_t b);
        if (a == b)
            return 0;
        if (order_q == ORDER_MAX_FIRST)
            return (a > b) ? 1 : -1;
        return (a < b) ? 1 : -1;
    endfunction

    function automatic heap_result_t heap_op_result(logic op, key_t k, payload_t p);
        heap_result_t r;
        int unsigned  pos;
        int unsigned  par;
        int unsigned  lc;
        int unsigned  rc;
        int unsigned  pick;
        key_t         last_k;
        payload_t     last_p;
        r = NO_RES;
        if (op == OP_INSERT)
        begin
            if (heap_size >= CAPACITY)
                r.status = ST_FULL;
            else
            begin
                pos = heap_size + 1;
                // climb past parents of strictly lower rank
                while (pos != 1)
                begin
                    par = pos / 2;
                    if (key_rank(heap_key[par], k) >= 0)
                        break;
                    heap_key[pos] = heap_key[par];
                    heap_pay[pos] = heap_pay[par];
                    pos = par;
                end
                heap_key[pos] = k;
                heap_pay[pos] = p;
                heap_size++;
            end
        end
        else if (heap_size == 0)
            r.status = ST_EMPTY;
        else
        begin
            last_k = heap_key[heap_size];
            last_p = heap_pay[heap_size];
            r.key = heap_key[1];
            r.payload = heap_pay[1];
            pos = 1;
            // the last entry still counts as a child during the descent
            forever
            begin
                lc = pos * 2;
                rc = lc + 1;
                if (lc > heap_size)
                    break;
                if (rc <= heap_size && key_rank(heap_key[lc], heap_key[rc]) < 0)
                    pick = rc;
                else
                    pick = lc;
                if (key_rank(last_k, heap_key[pick]) >= 0)
                    break;
                heap_key[pos] = heap_key[pick];
                heap_pay[pos] = heap_pay[pick];
                pos = pick;
            end
            heap_key[pos] = last_k;
            heap_pay[pos] = last_p;
            heap_size--;
        end
        r.count = count_t'(heap_size);
        return r;
    endfunction

    function automatic key_t pick_key();
        int unsigned sel;
        sel = $urandom_range(99);
        // narrow keys give plenty of ties
        if (sel < 25)
            return key_t'($urandom_range(7));
        if (sel < 35)
            return $urandom_range(1) ? '1 : '0;
        return key_t'($urandom);
    endfunction

    task automatic send_item(logic op, key_t k, payload_t p, bit typed, heap_result_t given);
        heap_result_t r;
        if ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.opcode  <= op;
        cmd_ch.key     <= k;
        cmd_ch.payload <= p;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        r = heap_op_result(op, k, p);
        pending_results.push_back(typed ? given : r);
    endtask

    task automatic wait_for_results();
        cmd_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_order(logic mode);
        wait_for_results();
        cfg_ch.valid      <= 1'b1;
        cfg_ch.order_mode <= mode;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        order_q = mode;
    endtask

    task automatic run_mixed(int n, int insert_pct);
        repeat (n)
            send_item(($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE,
                      pick_key(), payload_t'($urandom), 1'b0, NO_RES);
    endtask

    task automatic fill_heap(int extra);
        while (heap_size < CAPACITY)
            send_item(OP_INSERT, pick_key(), payload_t'($urandom), 1'b0, NO_RES);
        repeat (extra)
            send_item(OP_INSERT, pick_key(), payload_t'($urandom), 1'b0, NO_RES);
    endtask

    // receiver: random stalls, or a long hold-off while hold_left runs down
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left    <= hold_left - 1;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        heap_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected item key %h payload %h status %0d count %0d",
                             $realtime, rsp_ch.out_key, rsp_ch.out_payload, rsp_ch.status,
                             rsp_ch.entry_count);
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.out_key !== want.key || rsp_ch.out_payload !== want.payload
                    || rsp_ch.status !== want.status || rsp_ch.entry_count !== want.count)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: mismatch got %h/%h/%0d/%0d want %h/%h/%0d/%0d",
                                 $realtime, rsp_ch.out_key, rsp_ch.out_payload,
                                 rsp_ch.status, rsp_ch.entry_count, want.key, want.payload,
                                 want.status, want.count);
                end
            end
        end
    end

    initial
    begin
        rst_n             <= 1'b0;
        cmd_ch.valid      <= 1'b0;
        cmd_ch.opcode     <= OP_INSERT;
        cmd_ch.key        <= '0;
        cmd_ch.payload    <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.order_mode <= ORDER_MAX_FIRST;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
                write_order(dir_rows[i].mode);
            else
                send_item(dir_rows[i].op, dir_rows[i].key, dir_rows[i].payload,
                          dir_rows[i].typed, dir_rows[i].res);
        end

        run_mixed(60, 60);
        write_order(ORDER_MIN_FIRST);
        fill_heap(5);

        // flip the order on a full heap, then stall the output for a long stretch
        write_order(ORDER_MAX_FIRST);
        send_idle_pct = 52;
        recv_idle_pct = 7;
        hold_left <= 400;
        run_mixed(80, 20);

        write_order(ORDER_MIN_FIRST);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_mixed(80, 45);

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb_binary_heap_priority_queue: clean");
        else
            $display("tb_binary_heap_priority_queue: errors");
        $finish;
    end

endmodule
